/* sv/modulus_constraint_projection_unit_assert.svh */
// Assertion macros for the modulus constraint projection unit.
// Used by the top level only; depends on nothing else.
`ifndef MODULUS_CONSTRAINT_PROJECTION_UNIT_ASSERT_SVH
`define MODULUS_CONSTRAINT_PROJECTION_UNIT_ASSERT_SVH

`define MCP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

`define MCP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* sv/mcp_pkg.sv */
// Package for the modulus constraint projection unit.
// Holds widths, constants and the payload types of the cell chain; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package mcp_pkg;

  localparam int unsigned DW         = 32;
  localparam int unsigned FRAC_BITS  = 16;
  localparam int unsigned SQ_STEPS   = DW;
  localparam int unsigned DIV_STEPS  = DW;
  localparam int unsigned SW         = 2 * DW;
  localparam int unsigned KW         = $clog2(DIV_STEPS);

  localparam logic signed [DW-1:0] AMP_UNKNOWN = DW'(-(64'sd1 <<< FRAC_BITS));

  typedef struct packed {
    logic          bypass;
    logic          zero;
    logic          neg_r;
    logic          neg_i;
    logic [DW-1:0] raw_re;
    logic [DW-1:0] raw_im;
    logic [DW-1:0] raw_amp;
  } pay_t;

  typedef struct packed {
    logic [SW-1:0] x;
    logic [SW-1:0] res;
  } sq_t;

  typedef struct packed {
    logic [SW-1:0] rem_r;
    logic [SW-1:0] rem_i;
    logic [DW-1:0] q_r;
    logic [DW-1:0] q_i;
    logic [DW:0]   d;
  } div_t;

endpackage

`default_nettype wire

/* sv/mcp_sqrt_cell.sv */
// One cell of the integer square root chain: one result bit per cell.
// Depends on mcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcp_sqrt_cell import mcp_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [SW-1:0] bit_i,
  input  wire logic          valid_i,
  input  wire sq_t           sq_i,
  input  wire pay_t          pay_i,
  output logic               valid_o,
  output sq_t                sq_o,
  output pay_t               pay_o
);

  logic  valid_q;
  sq_t   sq_d, sq_q;
  pay_t  pay_q;
  logic [SW-1:0] trial;

  always_comb begin
    trial = sq_i.res + bit_i;
    if (sq_i.x >= trial) begin
      sq_d.x   = sq_i.x - trial;
      sq_d.res = (sq_i.res >> 1) + bit_i;
    end else begin
      sq_d.x   = sq_i.x;
      sq_d.res = sq_i.res >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q  <= sq_d;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign sq_o    = sq_q;
  assign pay_o   = pay_q;

endmodule

`default_nettype wire

/* sv/mcp_div_cell.sv */
// One cell of the restoring division chain: one quotient bit per lane per cell.
// Depends on mcp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mcp_div_cell import mcp_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic [KW-1:0] k_i,
  input  wire logic          valid_i,
  input  wire div_t          dv_i,
  input  wire pay_t          pay_i,
  output logic               valid_o,
  output div_t               dv_o,
  output pay_t               pay_o
);

  logic  valid_q;
  div_t  dv_d, dv_q;
  pay_t  pay_q;
  logic [SW:0] dsh;

  always_comb begin
    dsh  = {{(SW-DW){1'b0}}, dv_i.d} << k_i;
    dv_d = dv_i;
    if ({1'b0, dv_i.rem_r} >= dsh) begin
      dv_d.rem_r = dv_i.rem_r - dsh[SW-1:0];
      dv_d.q_r   = dv_i.q_r | (DW'(1) << k_i);
    end
    if ({1'b0, dv_i.rem_i} >= dsh) begin
      dv_d.rem_i = dv_i.rem_i - dsh[SW-1:0];
      dv_d.q_i   = dv_i.q_i | (DW'(1) << k_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q  <= dv_d;
      pay_q <= pay_i;
    end
  end

  assign valid_o = valid_q;
  assign dv_o    = dv_q;
  assign pay_o   = pay_q;

endmodule

`default_nettype wire

/* sv/modulus_constraint_projection_unit.sv */
// Top level of the modulus constraint projection unit.
// Depends on mcp_pkg, mcp_sqrt_cell, mcp_div_cell and the assertion header.
//
// Each input beat carries one spectrum pixel and its measured amplitude; each
// output beat carries the projected pixel. All values are signed Q16.16.
// One beat is accepted per cycle while the input side is not held, and results
// leave in input order. The pipeline is 3 front stages, 32 square root cells,
// one set-up stage, 32 division cells and the output register. A new beat can
// enter every cycle while the input side is not held, since each cell works
// out one result bit and then passes the beat on to the next cell.
// Reset empties the chain and the output register.
// When the receiver stalls, the chain keeps moving as long as its last cell
// is empty, so gaps close up; once a result waits in both the last cell and
// the output register, the whole chain and the input side hold.
`timescale 1ns / 1ps
`default_nettype none

module modulus_constraint_projection_unit import mcp_pkg::*; (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            s_axis_tvalid,
  output logic                 s_axis_tready,
  input  wire logic [3*DW-1:0] s_axis_tdata,  // pixel_re, pixel_im, measured_amplitude
  output logic                 m_axis_tvalid,
  input  wire logic            m_axis_tready,
  output logic [2*DW-1:0]      m_axis_tdata   // out_re, out_im
);

  logic en;

  logic [DW-1:0] in_re, in_im, in_amp;
  logic          in_neg_a;

  logic          s1_valid_q;
  pay_t          s1_pay_q;
  logic [DW-1:0] s1_ma_q, s1_mr_q, s1_mi_q;

  logic          s2_valid_q;
  pay_t          s2_pay_q;
  logic [SW-1:0] s2_sr_q, s2_si_q, s2_nr_q, s2_ni_q;

  logic          s3_valid_q;
  pay_t          s3_pay_q;
  logic [SW-1:0] s3_sum_q, s3_nr_q, s3_ni_q;

  logic          sq_valid [SQ_STEPS+1];
  sq_t           sq_data  [SQ_STEPS+1];
  pay_t          sq_pay   [SQ_STEPS+1];
  logic [SW-1:0] nr_pipe_q [SQ_STEPS];
  logic [SW-1:0] ni_pipe_q [SQ_STEPS];

  logic          dv_valid [DIV_STEPS+1];
  div_t          dv_data  [DIV_STEPS+1];
  pay_t          dv_pay   [DIV_STEPS+1];

  logic          setup_valid_q;
  div_t          setup_d, setup_q;
  pay_t          setup_pay_q;
  logic [DW-1:0] mag;

  logic          fin_valid;
  pay_t          fin_pay;
  logic [DW-1:0] res_re, res_im;
  logic          m_valid_d, m_valid_q;
  logic [2*DW-1:0] m_data_q;

  assign in_re    = s_axis_tdata[DW-1:0];
  assign in_im    = s_axis_tdata[2*DW-1:DW];
  assign in_amp   = s_axis_tdata[3*DW-1:2*DW];
  assign in_neg_a = in_amp[DW-1];

  assign fin_valid     = dv_valid[DIV_STEPS];
  assign fin_pay       = dv_pay[DIV_STEPS];
  assign en            = !fin_valid || !m_valid_q || m_axis_tready;
  assign s_axis_tready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      s2_valid_q    <= 1'b0;
      s3_valid_q    <= 1'b0;
      setup_valid_q <= 1'b0;
    end else if (en) begin
      s1_valid_q    <= s_axis_tvalid;
      s2_valid_q    <= s1_valid_q;
      s3_valid_q    <= s2_valid_q;
      setup_valid_q <= sq_valid[SQ_STEPS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_pay_q.bypass  <= $signed(in_amp) <= AMP_UNKNOWN;
      s1_pay_q.zero    <= (in_re == '0) && (in_im == '0);
      s1_pay_q.neg_r   <= in_neg_a ^ in_re[DW-1];
      s1_pay_q.neg_i   <= in_neg_a ^ in_im[DW-1];
      s1_pay_q.raw_re  <= in_re;
      s1_pay_q.raw_im  <= in_im;
      s1_pay_q.raw_amp <= in_amp;
      s1_ma_q <= in_neg_a ? DW'(-in_amp) : in_amp;
      s1_mr_q <= in_re[DW-1] ? DW'(-in_re) : in_re;
      s1_mi_q <= in_im[DW-1] ? DW'(-in_im) : in_im;

      s2_pay_q <= s1_pay_q;
      s2_sr_q  <= SW'(s1_mr_q) * SW'(s1_mr_q);
      s2_si_q  <= SW'(s1_mi_q) * SW'(s1_mi_q);
      s2_nr_q  <= SW'(s1_ma_q) * SW'(s1_mr_q);
      s2_ni_q  <= SW'(s1_ma_q) * SW'(s1_mi_q);

      s3_pay_q <= s2_pay_q;
      s3_sum_q <= s2_sr_q + s2_si_q;
      s3_nr_q  <= s2_nr_q;
      s3_ni_q  <= s2_ni_q;

      nr_pipe_q[0] <= s3_nr_q;
      ni_pipe_q[0] <= s3_ni_q;
      for (int i = 1; i < SQ_STEPS; i++) begin
        nr_pipe_q[i] <= nr_pipe_q[i-1];
        ni_pipe_q[i] <= ni_pipe_q[i-1];
      end

      setup_q     <= setup_d;
      setup_pay_q <= sq_pay[SQ_STEPS];
    end
  end

  assign sq_valid[0]  = s3_valid_q;
  assign sq_data[0].x   = s3_sum_q;
  assign sq_data[0].res = '0;
  assign sq_pay[0]    = s3_pay_q;

  for (genvar g = 0; g < SQ_STEPS; g++) begin : g_sqrt
    mcp_sqrt_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .bit_i   (SW'(1) << (SW - 2 - 2 * g)),
      .valid_i (sq_valid[g]),
      .sq_i    (sq_data[g]),
      .pay_i   (sq_pay[g]),
      .valid_o (sq_valid[g+1]),
      .sq_o    (sq_data[g+1]),
      .pay_o   (sq_pay[g+1])
    );
  end

  assign mag = sq_data[SQ_STEPS].res[DW-1:0];

  always_comb begin
    setup_d.rem_r = {nr_pipe_q[SQ_STEPS-1][SW-2:0], 1'b0} + SW'(mag);
    setup_d.rem_i = {ni_pipe_q[SQ_STEPS-1][SW-2:0], 1'b0} + SW'(mag);
    setup_d.q_r   = '0;
    setup_d.q_i   = '0;
    setup_d.d     = {mag, 1'b0};
  end

  assign dv_valid[0] = setup_valid_q;
  assign dv_data[0]  = setup_q;
  assign dv_pay[0]   = setup_pay_q;

  for (genvar g = 0; g < DIV_STEPS; g++) begin : g_div
    mcp_div_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .k_i     (KW'(DIV_STEPS - 1 - g)),
      .valid_i (dv_valid[g]),
      .dv_i    (dv_data[g]),
      .pay_i   (dv_pay[g]),
      .valid_o (dv_valid[g+1]),
      .dv_o    (dv_data[g+1]),
      .pay_o   (dv_pay[g+1])
    );
  end

  always_comb begin
    if (fin_pay.bypass) begin
      res_re = fin_pay.raw_re;
      res_im = fin_pay.raw_im;
    end else if (fin_pay.zero) begin
      res_re = fin_pay.raw_amp;
      res_im = '0;
    end else begin
      res_re = fin_pay.neg_r ? DW'(-dv_data[DIV_STEPS].q_r) : dv_data[DIV_STEPS].q_r;
      res_im = fin_pay.neg_i ? DW'(-dv_data[DIV_STEPS].q_i) : dv_data[DIV_STEPS].q_i;
    end
  end

  always_comb begin
    if (fin_valid && en) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end else begin
      m_valid_d = m_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_valid && en) begin
      m_data_q <= {res_im, res_re};
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

`include "modulus_constraint_projection_unit_assert.svh"

  `MCP_ASSERT_NOW(a_ready_when_empty, !m_valid_q, s_axis_tready)
  `MCP_ASSERT_NOW(a_hold_when_full, fin_valid && m_valid_q && !m_axis_tready, !s_axis_tready)
  `MCP_ASSERT_NEXT(a_load_on_last, fin_valid && en, m_axis_tvalid)

endmodule

`default_nettype wire

/* test/tb_top.sv */
// Testbench for the modulus constraint projection unit.
// Drives pixel beats with random bursts and gaps, predicts each projected pixel
// in-house and checks it against the output stream; depends on mcp_pkg and the top level.
`timescale 1ns / 1ps
`default_nettype none

module tb_top;
  import mcp_pkg::*;

  typedef struct packed {
    logic [DW-1:0] im;
    logic [DW-1:0] re;
  } proj_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [3*DW-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [2*DW-1:0] m_axis_tdata;

  proj_t  projected_q[$];
  int     errors = 0;
  int     burst_left = 0;
  bit     hold_off = 1'b0;
  bit     no_gaps = 1'b0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  modulus_constraint_projection_unit u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  function automatic logic [63:0] isqrt(logic [63:0] x);
    logic [63:0] r;
    logic [63:0] b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] absval(logic signed [DW-1:0] v);
    logic signed [63:0] w;
    w = v;
    return (w < 0) ? -w : w;
  endfunction

  function automatic logic [DW-1:0] scale(logic signed [DW-1:0] a, logic signed [DW-1:0] c,
                                          logic [63:0] m);
    logic [63:0] q;
    q = (2 * absval(a) * absval(c) + m) / (2 * m);
    if ((a < 0) != (c < 0)) q = -q;
    return q[DW-1:0];
  endfunction

  function automatic proj_t project(logic signed [DW-1:0] re, logic signed [DW-1:0] im,
                                    logic signed [DW-1:0] amp);
    proj_t       p;
    logic [63:0] m;
    if (amp <= AMP_UNKNOWN) begin
      p.re = re;
      p.im = im;
    end else if (re == 0 && im == 0) begin
      p.re = amp;
      p.im = '0;
    end else begin
      m = isqrt(absval(re) * absval(re) + absval(im) * absval(im));
      p.re = scale(amp, re, m);
      p.im = scale(amp, im, m);
    end
    return p;
  endfunction

  task automatic send_pixel(logic [DW-1:0] re, logic [DW-1:0] im, logic [DW-1:0] amp);
    int gap;
    while (!no_gaps && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0;
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {amp, im, re};
    projected_q.push_back(project(re, im, amp));
    do @(posedge clk_i); while (!s_axis_tready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (projected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic test_directed();
    logic [DW-1:0] ext[8];
    ext = '{32'h0, 32'h1, 32'hFFFFFFFF, 32'h7FFFFFFF, 32'h80000000,
            32'h00010000, 32'hFFFF0000, 32'hFFFF0001};
    send_pixel(32'h0, 32'h0, 32'h00020000);
    send_pixel(32'h0, 32'h0, 32'hFFFF8000);
    send_pixel(32'h12345678, 32'h9ABCDEF0, AMP_UNKNOWN);
    send_pixel(32'h12345678, 32'h9ABCDEF0, 32'h80000000);
    send_pixel(32'h00030000, 32'h00040000, 32'hFFFF8000);
    send_pixel(32'h80000000, 32'h80000000, 32'h7FFFFFFF);
    send_pixel(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
    send_pixel(32'h00000001, 32'h00000001, 32'h00000003);
    for (int i = 0; i < 8; i++) send_pixel(ext[i], ext[7 - i], ext[(i + 3) % 8]);
    for (int i = 0; i < 8; i++) send_pixel(ext[i], ext[i], ext[7 - i]);
    drain();
  endtask

  task automatic test_random(int n);
    logic [DW-1:0] re, im, amp;
    for (int i = 0; i < n; i++) begin
      re = $urandom();
      im = $urandom();
      case ($urandom_range(0, 5))
        0: amp = $urandom();
        1: amp = AMP_UNKNOWN - $urandom_range(0, 3);
        2: amp = -$urandom_range(0, 32'h10000);
        default: amp = $urandom_range(0, 32'h7FFFFFFF);
      endcase
      if ($urandom_range(0, 3) == 0) re = $signed(re) >>> $urandom_range(0, 31);
      if ($urandom_range(0, 3) == 0) im = $signed(im) >>> $urandom_range(0, 31);
      if ($urandom_range(0, 30) == 0) begin
        re = 0;
        im = 0;
      end
      send_pixel(re, im, amp);
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    no_gaps  = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      test_random(200);
    join
    no_gaps = 1'b0;
    drain();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(500);
    drain();
    test_backpressure();
    test_random(530);
    drain();
    repeat (100) @(posedge clk_i);
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) begin
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 7) != 0) || ($urandom_range(0, 1) == 0);
    end
  end

  always @(posedge clk_i) begin
    proj_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (projected_q.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, got);
        errors++;
      end else begin
        want = projected_q.pop_front();
        if (got.re !== want.re) begin
          $display("%0t: out_re expected %h actual %h", $time, want.re, got.re);
          errors++;
        end
        if (got.im !== want.im) begin
          $display("%0t: out_im expected %h actual %h", $time, want.im, got.im);
          errors++;
        end
      end
    end
  end

  initial begin
    #2ms;
    $display("RESULT: ERROR");
    $finish;
  end
endmodule

`default_nettype wire

/* modulus_constraint_projection_unit.f */
+incdir+sv
sv/mcp_pkg.sv
sv/mcp_sqrt_cell.sv
sv/mcp_div_cell.sv
sv/modulus_constraint_projection_unit.sv
test/tb_top.sv
